FILE: sv/dmhq_pkg.sv
`default_nettype none
package dmhq_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int unsigned CAPACITY_DEF  = 1024;
  localparam int unsigned MAX_ARITY_DEF = 8;

  // Fixed field widths
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned ARITY_W = 4;
  localparam int unsigned STAT_W  = 2;

  localparam logic [ARITY_W-1:0] ARITY_RST = ARITY_W'(2);

  // Request kinds
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Result handed from the controller to the output register
  typedef struct packed {
    logic signed [KEY_W-1:0] max_key;
    status_e                 status;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/dmhq_ram.sv
`default_nettype none
module dmhq_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: sv/dmhq_ctrl.sv
`default_nettype none
module dmhq_ctrl #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned MAX_ARITY = 8,
  parameter int unsigned IW        = 10,
  parameter int unsigned CW        = 11
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [dmhq_pkg::ARITY_W-1:0]   arity_i,
  input  wire logic                           req_valid_i,
  output logic                                req_stall_o,
  input  wire logic                           mode_i,
  input  wire logic signed [dmhq_pkg::KEY_W-1:0] key_i,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output dmhq_pkg::res_t                      res_o,
  output logic [CW-1:0]                       res_count_o
);
  import dmhq_pkg::*;

  localparam int unsigned KW = $clog2(MAX_ARITY + 1);
  localparam int unsigned SH = IW + KW;          // reciprocal shift
  localparam int unsigned PW = IW + SH + 1;      // product width
  localparam int unsigned BW = IW + KW + 1;      // first-child index width

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_UP_CHK  = 11'b000_0000_0010,
    S_UP_RD   = 11'b000_0000_0100,
    S_UP_CMP  = 11'b000_0000_1000,
    S_EX_RD   = 11'b000_0001_0000,
    S_EX_LAST = 11'b000_0010_0000,
    S_DN_CHK  = 11'b000_0100_0000,
    S_DN_TST  = 11'b000_1000_0000,
    S_DN_SCAN = 11'b001_0000_0000,
    S_DN_DEC  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [IW-1:0]           pos_q, pos_d;
  logic [IW-1:0]           par_q, par_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [PW-1:0]           prod_q, prod_d;
  logic [BW-1:0]           base_q, base_d;
  logic [IW-1:0]           rd_idx_q, rd_idx_d;
  logic [KW-1:0]           j_q, j_d;
  logic                    found_q, found_d;
  logic [IW-1:0]           best_q, best_d;
  logic signed [KEY_W-1:0] best_val_q, best_val_d;
  res_t                    res_q, res_d;

  logic [KW-1:0]           k_live;
  logic [SH:0]             recip_tab [MAX_ARITY+1];
  logic [CW-1:0]           nxt;

  // RAM port
  logic                    ram_re, ram_we;
  logic [IW-1:0]           ram_raddr, ram_waddr;
  logic [KEY_W-1:0]        ram_wdata, ram_rdata;
  logic signed [KEY_W-1:0] rd_val;

  // Reciprocals for exact division by the arity: floor(x * m >> SH)
  for (genvar g = 0; g <= MAX_ARITY; g++) begin : g_recip
    if (g < 2) begin : g_none
      assign recip_tab[g] = '0;
    end else begin : g_val
      localparam longint unsigned RV = ((64'd1 << SH) + g - 1) / g;
      assign recip_tab[g] = RV[SH:0];
    end
  end

  // Arity clamped to the supported range
  always_comb begin
    if (arity_i < ARITY_W'(2)) begin
      k_live = KW'(2);
    end else if (int'(arity_i) > int'(MAX_ARITY)) begin
      k_live = KW'(MAX_ARITY);
    end else begin
      k_live = KW'(arity_i);
    end
  end

  dmhq_ram #(
    .DEPTH(CAPACITY),
    .AW   (IW),
    .DW   (KEY_W)
  ) u_ram (
    .clk_i  (clk_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata)
  );

  assign rd_val = signed'(ram_rdata);
  assign nxt    = CW'(rd_idx_q) + CW'(1);

  // Sequencer: sift up / sift down through the RAM
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    par_d      = par_q;
    key_d      = key_q;
    prod_d     = prod_q;
    base_d     = base_q;
    rd_idx_d   = rd_idx_q;
    j_d        = j_q;
    found_d    = found_q;
    best_d     = best_q;
    best_val_d = best_val_q;
    res_d      = res_q;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    ram_waddr  = pos_q;
    ram_wdata  = key_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          res_d.max_key = '0;
          res_d.status  = ST_OK;
          if (mode_i == MODE_INSERT) begin
            if (cnt_q == CW'(CAPACITY)) begin
              res_d.status = ST_FULL;
              state_d      = S_DONE;
            end else begin
              pos_d   = IW'(cnt_q);
              key_d   = key_i;
              cnt_d   = cnt_q + CW'(1);
              state_d = S_UP_CHK;
            end
          end else begin
            if (cnt_q == '0) begin
              res_d.status = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_d   = S_EX_RD;
            end
          end
        end
      end

      S_UP_CHK: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          prod_d  = PW'(pos_q - IW'(1)) * PW'(recip_tab[k_live]);
          state_d = S_UP_RD;
        end
      end

      S_UP_RD: begin
        par_d     = prod_q[SH +: IW];
        ram_re    = 1'b1;
        ram_raddr = prod_q[SH +: IW];
        state_d   = S_UP_CMP;
      end

      S_UP_CMP: begin
        ram_we = 1'b1;
        if (key_q > rd_val) begin
          // parent moves down, keep climbing
          ram_wdata = ram_rdata;
          pos_d     = par_q;
          state_d   = S_UP_CHK;
        end else begin
          state_d = S_DONE;
        end
      end

      S_EX_RD: begin
        res_d.max_key = rd_val;
        ram_re        = 1'b1;
        ram_raddr     = IW'(cnt_q - CW'(1));
        state_d       = S_EX_LAST;
      end

      S_EX_LAST: begin
        // last entry becomes the moving key at the root
        key_d = rd_val;
        cnt_d = cnt_q - CW'(1);
        pos_d = '0;
        if (cnt_q == CW'(1)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DN_CHK;
        end
      end

      S_DN_CHK: begin
        base_d  = BW'(pos_q) * BW'(k_live) + BW'(1);
        state_d = S_DN_TST;
      end

      S_DN_TST: begin
        if (base_q >= BW'(cnt_q)) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = base_q[IW-1:0];
          rd_idx_d  = base_q[IW-1:0];
          j_d       = KW'(1);
          found_d   = 1'b0;
          state_d   = S_DN_SCAN;
        end
      end

      S_DN_SCAN: begin
        // first strictly larger child wins ties
        if (!found_q || rd_val > best_val_q) begin
          best_d     = rd_idx_q;
          best_val_d = rd_val;
        end
        found_d = 1'b1;
        if (j_q < k_live && nxt < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = IW'(nxt);
          rd_idx_d  = IW'(nxt);
          j_d       = j_q + KW'(1);
        end else begin
          state_d = S_DN_DEC;
        end
      end

      S_DN_DEC: begin
        ram_we = 1'b1;
        if (key_q < best_val_q) begin
          ram_wdata = best_val_q;
          pos_d     = best_q;
          state_d   = S_DN_CHK;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    par_q      <= par_d;
    key_q      <= key_d;
    prod_q     <= prod_d;
    base_q     <= base_d;
    rd_idx_q   <= rd_idx_d;
    j_q        <= j_d;
    best_q     <= best_d;
    best_val_q <= best_val_d;
    res_q      <= res_d;
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign res_count_o = cnt_q;

`ifndef SYNTHESIS
  a_no_rw_same_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("RAM read and write in one cycle");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_done_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_ready_i) |=> (state_q == S_DONE && $stable(res_q)))
    else $error("result dropped before hand-off");

  a_count_fixed_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_CHK || state_q == S_UP_RD || state_q == S_UP_CMP) |=> $stable(cnt_q))
    else $error("count changed during sift up");
`endif

endmodule
`default_nettype wire

FILE: sv/dary_max_heap_queue.sv
// Channel   Handshake                    Payload
// in        in_valid_i / in_stall_o      mode_i, key_i
// out       out_valid_o / out_stall_i    max_key_o, status_o, count_o
// cfg       cfg_we_i                     cfg_wdata_i (arity)
//
// One request at a time: the input stalls until the previous one is done.
// A full insert or an empty extract only returns its status. An insert climbs
// from the new leaf, one parent read and compare per level; an extract reads
// the root and the last entry, then descends, reading the children of each
// node in turn. The single read port of the heap RAM sets the pace. Reset
// clears the entry count and sets arity to 2; the RAM needs no clearing. A
// stalled result waits in the output register while the next request runs.
`default_nettype none
module dary_max_heap_queue #(
  parameter int unsigned CAPACITY  = dmhq_pkg::CAPACITY_DEF,
  parameter int unsigned MAX_ARITY = dmhq_pkg::MAX_ARITY_DEF,
  localparam int unsigned IW       = $clog2(CAPACITY),
  localparam int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [dmhq_pkg::ARITY_W-1:0]        cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                mode_i,
  input  wire logic signed [dmhq_pkg::KEY_W-1:0]   key_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [dmhq_pkg::KEY_W-1:0]        max_key_o,
  output logic [dmhq_pkg::STAT_W-1:0]              status_o,
  output logic [CW-1:0]                            count_o
);
  import dmhq_pkg::*;

  logic [ARITY_W-1:0] arity_q;
  logic               res_valid, res_ready;
  res_t               res;
  logic [CW-1:0]      res_count;
  logic               out_valid_q;
  res_t               out_q;
  logic [CW-1:0]      out_cnt_q;

  // Arity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arity_q <= ARITY_RST;
    end else if (cfg_we_i) begin
      arity_q <= cfg_wdata_i;
    end
  end

  dmhq_ctrl #(
    .CAPACITY (CAPACITY),
    .MAX_ARITY(MAX_ARITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .arity_i    (arity_q),
    .req_valid_i(in_valid_i),
    .req_stall_o(in_stall_o),
    .mode_i     (mode_i),
    .key_i      (key_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .res_count_o(res_count)
  );

  // Output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q     <= res;
      out_cnt_q <= res_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_key_o   = out_q.max_key;
  assign status_o    = out_q.status;
  assign count_o     = out_cnt_q;

endmodule
`default_nettype wire
